>>> src/caf_pkg.sv
// shared types and constants of the command apdu framer
package caf_pkg;

    localparam int unsigned CAF_FIFO_DEPTH = 4;
    localparam int unsigned CAF_MAX_BEATS  = 7;

    localparam logic [15:0] LC_SHORT_MAX   = 16'h00FF;
    localparam logic [15:0] LE_SHORT_LIMIT = 16'h0100;
    localparam logic [7:0]  LONG_TOKEN     = 8'h00;

    typedef enum logic [0:0] {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // one queue entry: a run of up to seven output beats
    typedef struct packed {
        logic [CAF_MAX_BEATS-1:0][7:0] bytes;
        logic [2:0]                    count;
        logic                          last;
        status_t                       status;
        logic [16:0]                   total;
    } cmd_t;

endpackage

>>> src/caf_item_if.sv
// input channel: header items and data bytes
interface caf_item_if import caf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  cmd_class;
    logic [7:0]  instruction;
    logic [15:0] parameter_req;
    logic        has_data;
    logic [15:0] data_len;
    logic [15:0] expected_len;
    logic [15:0] buffer_capacity;
    logic [7:0]  data_byte;

    modport source (
        output valid, kind, cmd_class, instruction, parameter_req, has_data,
        output data_len, expected_len, buffer_capacity, data_byte,
        input  ready
    );

    modport sink (
        input  valid, kind, cmd_class, instruction, parameter_req, has_data,
        input  data_len, expected_len, buffer_capacity, data_byte,
        output ready
    );
endinterface

>>> src/caf_frame_if.sv
// output channel: encoded frame bytes
interface caf_frame_if import caf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  status;
    logic [16:0] total_length;

    modport source (
        output valid, out_byte, last, status, total_length,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last, status, total_length,
        output ready
    );
endinterface

>>> src/caf_front.sv
// front end: frame state, length check and beat-run building
module caf_front import caf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    caf_item_if.sink   item,
    output logic       push,
    output cmd_t       push_data,
    input  logic       push_ready
);

    logic        in_data_phase_reg, in_data_phase_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [15:0] pending_le_reg, pending_le_next;
    logic [16:0] frame_length_reg, frame_length_next;

    logic        accept;
    logic        emit;
    logic        final_byte;
    logic        long_lc;
    logic        long_le;
    logic [16:0] total;
    cmd_t        cmd;

    assign item.ready = push_ready;
    assign accept     = item.valid && item.ready;
    assign long_lc    = item.data_len > LC_SHORT_MAX;
    assign long_le    = item.expected_len > LE_SHORT_LIMIT;
    assign final_byte = bytes_remaining_reg <= 16'd1;

    always_comb
    begin
        total = 17'd4;
        if (item.has_data)
        begin
            total = total + {1'b0, item.data_len} + (long_lc ? 17'd3 : 17'd1);
        end
        if (item.expected_len != 16'd0)
        begin
            total = total + (long_le ? 17'd2 : 17'd1);
        end
    end

    always_comb
    begin
        cmd                  = '0;
        emit                 = 1'b0;
        in_data_phase_next   = in_data_phase_reg;
        bytes_remaining_next = bytes_remaining_reg;
        pending_le_next      = pending_le_reg;
        frame_length_next    = frame_length_reg;
        cmd.status           = STATUS_OK;
        case (kind_t'(item.kind))
            KIND_HEADER:
            begin
                emit                 = 1'b1;
                in_data_phase_next   = 1'b0;
                bytes_remaining_next = '0;
                pending_le_next      = '0;
                if (item.has_data && item.data_len == 16'd0)
                begin
                    frame_length_next = '0;
                    cmd.bytes[0]      = 8'h00;
                    cmd.count         = 3'd1;
                    cmd.last          = 1'b1;
                    cmd.status        = STATUS_EMPTY;
                    cmd.total         = '0;
                end
                else if (total > {1'b0, item.buffer_capacity})
                begin
                    frame_length_next = total;
                    cmd.bytes[0]      = 8'h00;
                    cmd.count         = 3'd1;
                    cmd.last          = 1'b1;
                    cmd.status        = STATUS_OVERFLOW;
                    cmd.total         = total;
                end
                else
                begin
                    frame_length_next = total;
                    cmd.total         = total;
                    cmd.bytes[0]      = item.cmd_class;
                    cmd.bytes[1]      = item.instruction;
                    cmd.bytes[2]      = item.parameter_req[15:8];
                    cmd.bytes[3]      = item.parameter_req[7:0];
                    cmd.count         = 3'd4;
                    cmd.last          = !item.has_data;
                    if (item.has_data)
                    begin
                        in_data_phase_next   = 1'b1;
                        bytes_remaining_next = item.data_len;
                        pending_le_next      = item.expected_len;
                        if (long_lc)
                        begin
                            cmd.bytes[4] = LONG_TOKEN;
                            cmd.bytes[5] = item.data_len[15:8];
                            cmd.bytes[6] = item.data_len[7:0];
                            cmd.count    = 3'd7;
                        end
                        else
                        begin
                            cmd.bytes[4] = item.data_len[7:0];
                            cmd.count    = 3'd5;
                        end
                    end
                    else if (item.expected_len != 16'd0)
                    begin
                        if (long_le)
                        begin
                            cmd.bytes[4] = item.expected_len[15:8];
                            cmd.bytes[5] = item.expected_len[7:0];
                            cmd.count    = 3'd6;
                        end
                        else
                        begin
                            // 256 encodes as a single zero byte
                            cmd.bytes[4] = item.expected_len[7:0];
                            cmd.count    = 3'd5;
                        end
                    end
                end
            end
            KIND_DATA:
            begin
                emit         = in_data_phase_reg;
                cmd.total    = frame_length_reg;
                cmd.bytes[0] = item.data_byte;
                cmd.count    = 3'd1;
                cmd.last     = final_byte;
                if (in_data_phase_reg)
                begin
                    if (final_byte)
                    begin
                        in_data_phase_next   = 1'b0;
                        bytes_remaining_next = '0;
                        pending_le_next      = '0;
                        if (pending_le_reg > LE_SHORT_LIMIT)
                        begin
                            cmd.bytes[1] = pending_le_reg[15:8];
                            cmd.bytes[2] = pending_le_reg[7:0];
                            cmd.count    = 3'd3;
                        end
                        else if (pending_le_reg != 16'd0)
                        begin
                            cmd.bytes[1] = pending_le_reg[7:0];
                            cmd.count    = 3'd2;
                        end
                    end
                    else
                    begin
                        bytes_remaining_next = bytes_remaining_reg - 16'd1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push      = accept && emit;
    assign push_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_data_phase_reg   <= 1'b0;
            bytes_remaining_reg <= '0;
            pending_le_reg      <= '0;
            frame_length_reg    <= '0;
        end
        else if (accept)
        begin
            in_data_phase_reg   <= in_data_phase_next;
            bytes_remaining_reg <= bytes_remaining_next;
            pending_le_reg      <= pending_le_next;
            frame_length_reg    <= frame_length_next;
        end
    end

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_data_phase_reg |-> (bytes_remaining_reg == '0 && pending_le_reg == '0))
        else $error("idle front holds stale frame state");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("front pushed into a full queue");

    a_phase_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_data_phase_reg |-> frame_length_reg > 17'd5)
        else $error("data phase without a valid frame length");

endmodule

>>> src/caf_fifo.sv
// queue of beat runs between front and back
module caf_fifo import caf_pkg::*; #(
    parameter int unsigned DEPTH = CAF_FIFO_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic push_ready,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with diverged pointers");

    a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drain an entry");

endmodule

>>> src/caf_back.sv
// back end: walks each beat run out onto the frame channel
module caf_back import caf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    caf_frame_if.source frame
);

    logic [2:0] idx_reg, idx_next;
    logic       beat_done;
    logic       run_end;

    assign run_end   = idx_reg == (head.count - 3'd1);
    assign beat_done = frame.valid && frame.ready;
    assign pop       = beat_done && run_end;

    assign frame.valid        = head_valid;
    assign frame.out_byte     = head.bytes[idx_reg];
    assign frame.last         = head.last && run_end;
    assign frame.status       = head.status;
    assign frame.total_length = head.total;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (beat_done)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.count)
        else $error("beat index past end of run");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == '0)
        else $error("beat index left over without a run");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.status != STATUS_OK) |-> (head.count == 3'd1 && head.last))
        else $error("error run longer than one beat");

endmodule

>>> src/command_apdu_framer.sv
// top level of the command apdu framer
// Takes one input beat per cycle whenever the run queue has room: a header beat turns into
// a run of 1 to 7 frame bytes (one error byte, or CLA INS P1 P2 and Lc, or Le when there is
// no data field), a data beat in a data field into 1 to 3 bytes (the byte itself and Le after
// the last one); data beats outside a data field are dropped. The output side sends one frame
// byte per cycle while the frame sink is ready, so streamed data then sustains one beat per
// cycle, and a header run holds the output until all its bytes are sent; the FIFO_DEPTH-entry
// run queue between the two sides absorbs that expansion and lets either side stall alone.
module command_apdu_framer import caf_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = CAF_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    caf_item_if.sink    item,
    caf_frame_if.source frame
);

    logic push;
    logic push_ready;
    logic head_valid;
    logic pop;
    cmd_t push_data;
    cmd_t head;

    caf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    caf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    caf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .frame      (frame)
    );

endmodule
